// ----- src/sidc_pkg.sv -----
// ----------------------------------------------------------------------------
// sidc_pkg
// Shared types and constants for the signed integer to decimal ASCII block.
// ----------------------------------------------------------------------------
package sidc_pkg;

    localparam int VALUE_W    = 32;
    localparam int CHAR_W     = 8;
    localparam int DIGIT_W    = 4;
    localparam int NUM_DIGITS = 10;
    localparam int CNT_W      = $clog2(VALUE_W);
    localparam int LEFT_W     = $clog2(NUM_DIGITS + 1);

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;
    localparam logic [3:0]        CHAR_HIGH  = 4'h3;

    typedef struct packed {
        logic clear;
        logic dabble;
        logic shift;
    } t_cell_ctl;

    typedef struct packed {
        logic               carry;
        logic [DIGIT_W-1:0] digit;
    } t_cell_link;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_CONV = 5'b00010,
        S_SKIP = 5'b00100,
        S_SIGN = 5'b01000,
        S_DIGS = 5'b10000
    } t_state;

endpackage

// ----- src/sidc_if.sv -----
// ----------------------------------------------------------------------------
// sidc_if
// Valid/ready channels: integer input and character output.
// ----------------------------------------------------------------------------
interface sidc_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface sidc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

// ----- src/sidc_bcd_cell.sv -----
// ----------------------------------------------------------------------------
// sidc_bcd_cell
// One BCD digit of the conversion chain: add-3 and shift during conversion,
// digit hand-up toward the most significant end during output.
// ----------------------------------------------------------------------------
module sidc_bcd_cell (
    input  logic                i_clk,
    input  sidc_pkg::t_cell_ctl  i_ctl,
    input  sidc_pkg::t_cell_link i_prev,
    output sidc_pkg::t_cell_link o_next
);
    import sidc_pkg::*;

    logic [DIGIT_W-1:0] r_digit;
    logic [DIGIT_W-1:0] n_digit;
    logic [DIGIT_W-1:0] w_adj;

    always_comb begin
        w_adj = (r_digit >= 4'd5) ? (r_digit + 4'd3) : r_digit;
        n_digit = r_digit;
        if (i_ctl.clear) begin
            n_digit = '0;
        end else if (i_ctl.dabble) begin
            n_digit = {w_adj[DIGIT_W-2:0], i_prev.carry};
        end else if (i_ctl.shift) begin
            n_digit = i_prev.digit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

    assign o_next.carry = w_adj[DIGIT_W-1];
    assign o_next.digit = r_digit;

endmodule

// ----- src/signed_int_to_decimal_ascii.sv -----
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Signed 32-bit integer to decimal ASCII text, most significant char first.
// Operation: accepts one integer, runs one double-dabble step per input bit
//   through the digit chain, drops leading zeros, then sends one character
//   per cycle while the output is ready, the minus sign first if negative.
// A new integer is accepted only after the last character has been issued.
// Reset: synchronous active low; clears the state machine and output valid.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sidc_in_if.sink    i_in,
    sidc_out_if.source o_out
);
    import sidc_pkg::*;

    t_state                r_state, n_state;
    logic [VALUE_W-1:0]    r_mag, n_mag;
    logic                  r_neg, n_neg;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [LEFT_W-1:0]     r_left, n_left;
    logic                  r_out_valid, n_out_valid;
    logic [CHAR_W-1:0]     r_char, n_char;
    logic                  r_last, n_last;

    t_cell_ctl             w_ctl;
    t_cell_link            w_link [NUM_DIGITS+1];
    logic [DIGIT_W-1:0]    w_top;
    logic                  w_push;

    assign w_link[0].carry = r_mag[VALUE_W-1];
    assign w_link[0].digit = '0;
    assign w_top           = w_link[NUM_DIGITS].digit;

    genvar g;
    generate
        for (g = 0; g < NUM_DIGITS; g++) begin : g_cell
            sidc_bcd_cell u_cell (
                .i_clk  (i_clk),
                .i_ctl  (w_ctl),
                .i_prev (w_link[g]),
                .o_next (w_link[g+1])
            );
        end
    endgenerate

    assign i_in.ready      = (r_state == S_IDLE);
    assign o_out.valid     = r_out_valid;
    assign o_out.char_code = r_char;
    assign o_out.last_char = r_last;
    assign w_push          = !r_out_valid || o_out.ready;

    always_comb begin
        n_state     = r_state;
        n_mag       = r_mag;
        n_neg       = r_neg;
        n_cnt       = r_cnt;
        n_left      = r_left;
        n_out_valid = r_out_valid && !o_out.ready;
        n_char      = r_char;
        n_last      = r_last;
        w_ctl       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_neg     = i_in.value[VALUE_W-1];
                    n_mag     = i_in.value[VALUE_W-1] ? (~i_in.value + 32'd1) : i_in.value;
                    n_cnt     = '0;
                    w_ctl.clear = 1'b1;
                    n_state   = S_CONV;
                end
            end
            S_CONV: begin
                w_ctl.dabble = 1'b1;
                n_mag = {r_mag[VALUE_W-2:0], 1'b0};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(VALUE_W - 1)) begin
                    n_left  = LEFT_W'(NUM_DIGITS);
                    n_state = S_SKIP;
                end
            end
            S_SKIP: begin
                if (w_top == '0 && r_left > LEFT_W'(1)) begin
                    w_ctl.shift = 1'b1;
                    n_left = r_left - 1'b1;
                end else begin
                    n_state = r_neg ? S_SIGN : S_DIGS;
                end
            end
            S_SIGN: begin
                if (w_push) begin
                    n_out_valid = 1'b1;
                    n_char      = CHAR_MINUS;
                    n_last      = 1'b0;
                    n_state     = S_DIGS;
                end
            end
            S_DIGS: begin
                if (w_push) begin
                    n_out_valid = 1'b1;
                    n_char      = {CHAR_HIGH, w_top};
                    n_last      = (r_left == LEFT_W'(1));
                    w_ctl.shift = 1'b1;
                    n_left      = r_left - 1'b1;
                    if (r_left == LEFT_W'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_mag  <= n_mag;
        r_neg  <= n_neg;
        r_cnt  <= n_cnt;
        r_left <= n_left;
        r_char <= n_char;
        r_last <= n_last;
    end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks signed_int_to_decimal_ascii: every integer sent on the input channel
// is turned into its expected decimal characters by a local predictor, and
// each character transaction on the output channel is compared against the
// oldest expected one. Both channels idle at random, except in one stretch.
// ----------------------------------------------------------------------------
module testbench;
    import sidc_pkg::*;

    localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'd48;
    localparam int IDLE_PCT = 16;
    localparam int SETTLE_CYCLES = 60;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } t_text_char;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic no_idle = 1'b0;
    int   mismatches = 0;

    t_text_char expected_chars[$];

    sidc_in_if  in_if();
    sidc_out_if out_if();

    signed_int_to_decimal_ascii DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        in_if.valid  = 1'b0;
        in_if.value  = '0;
        out_if.ready = 1'b0;
    end

    initial begin
        #5ms;
        $display("testbench NOT OK");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // Expected characters for one integer: sign, then digits high to low.
    function automatic void predict_text(input logic [VALUE_W-1:0] value);
        logic [VALUE_W-1:0]  mag;
        logic [DIGIT_W-1:0]  digs[NUM_DIGITS];
        int                  ndig;
        t_text_char          ch;
        ndig = 0;
        mag = value[VALUE_W-1] ? (~value + 1'b1) : value;
        do begin
            digs[ndig] = DIGIT_W'(mag % 10);
            ndig++;
            mag = mag / 10;
        end while (mag != 0);
        if (value[VALUE_W-1]) begin
            ch.code = CHAR_MINUS;
            ch.last = 1'b0;
            expected_chars.push_back(ch);
        end
        for (int k = ndig - 1; k >= 0; k--) begin
            ch.code = CHAR_ZERO + CHAR_W'(digs[k]);
            ch.last = (k == 0);
            expected_chars.push_back(ch);
        end
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_value(input logic [VALUE_W-1:0] value);
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.value <= value;
        do @(posedge i_clk); while (!in_if.ready);
        predict_text(value);
        @(negedge i_clk);
    endtask

    task automatic wait_for_text;
        in_if.valid <= 1'b0;
        while (expected_chars.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic [VALUE_W-1:0] random_value();
        logic [VALUE_W-1:0] v;
        v = $urandom;
        if ($urandom_range(3) != 0) begin
            v = v >> $urandom_range(VALUE_W - 1);
            if ($urandom_range(1)) v = ~v + 1'b1;
        end
        return v;
    endfunction

    task automatic test_special_values;
        send_value(32'd0);
        send_value(32'd1);
        send_value(-32'sd1);
        send_value(32'h7FFF_FFFF);
        send_value(32'h8000_0000);
        send_value(32'd9);
        send_value(-32'sd9);
    endtask

    task automatic test_digit_counts;
        logic [VALUE_W-1:0] p;
        p = 32'd10;
        for (int k = 1; k <= 9; k++) begin
            send_value(p - 1'b1);
            send_value(~p + 1'b1);
            p = p * 10;
        end
    endtask

    task automatic test_random_values;
        for (int n = 0; n < 100; n++) send_value(random_value());
    endtask

    task automatic test_pause_until_empty;
        for (int n = 0; n < 3; n++) send_value(random_value());
        wait_for_text();
        send_value(32'h8000_0000);
        send_value(32'd0);
    endtask

    task automatic test_no_idling;
        no_idle = 1'b1;
        for (int n = 0; n < 30; n++) send_value(random_value());
        no_idle = 1'b0;
    endtask

    always @(negedge i_clk) begin
        out_if.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin
        t_text_char want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (expected_chars.size() == 0) begin
                report_mismatch($sformatf("unexpected char %0d last %0b",
                                          out_if.char_code, out_if.last_char));
            end else begin
                want = expected_chars.pop_front();
                if (out_if.char_code !== want.code)
                    report_mismatch($sformatf("char_code %0d, expected %0d",
                                              out_if.char_code, want.code));
                if (out_if.last_char !== want.last)
                    report_mismatch($sformatf("last_char %0b, expected %0b",
                                              out_if.last_char, want.last));
            end
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_special_values();
        test_digit_counts();
        test_random_values();
        test_pause_until_empty();
        test_no_idling();

        wait_for_text();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_chars.size() == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
